@@ rtl/tsm_pkg.sv @@
// Shared constants, types and the tanh table for the tanh saturator.
// Used by the datapath top level and its port checker.
`default_nettype none

package tsm_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int TANH_ENTRIES = 256;
  localparam int TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int GAIN_W   = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_PRE_GAIN = 2'd0;
  localparam logic [1:0] REG_SAT      = 2'd1;
  localparam logic [1:0] REG_POST     = 2'd2;
  localparam logic [1:0] REG_WET      = 2'd3;

  // Datapath widths
  localparam int IDX_W   = $clog2(TANH_ENTRIES);
  localparam int FRAC_W  = 33 - IDX_W;
  localparam int DIFF_W  = FRAC_W + 1;
  localparam int T_W     = 31;
  localparam int KS_W    = 20;
  localparam int U_W     = 36;
  localparam int RC_W    = 37;
  localparam int RC_LO_W = 19;
  localparam int DIV_N_W = 41;
  localparam int DIV_R_W = KS_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam logic [SAMPLE_BITS-1:0] FS_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] FS_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic [T_W-1:0] tanh_rom_t [0:TANH_ENTRIES];

  // unsigned shift-subtract quotient, table build only
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned dv);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= dv) begin
        r    = r - dv;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(n * 8 / TANH_ENTRIES) in Q30, built with the addition formula
  function automatic tanh_rom_t build_tanh_rom();
    longint unsigned h;
    longint unsigned h2;
    longint unsigned pk;
    longint unsigned th;
    longint unsigned t;
    longint unsigned d;
    longint          s;
    longint          prod;
    longint          num [0:4];
    longint          den [0:4];
    tanh_rom_t       rom;
    num = '{-1, 2, -17, 62, -1382};
    den = '{3, 15, 315, 2835, 155925};
    h  = ((longint'(8) << 30) + (TANH_ENTRIES >> 1)) >> IDX_W;
    h2 = (h * h + (longint'(1) << 29)) >> 30;
    pk = longint'(1) << 30;
    s  = longint'(1) << 30;
    t  = 0;
    for (int i = 0; i < 5; i++) begin
      pk   = (pk * h2 + (longint'(1) << 29)) >> 30;
      prod = longint'(pk) * num[i];
      if (prod < 0) begin
        s = s - longint'(div_u64(-prod, den[i]));
      end else begin
        s = s + longint'(div_u64(prod, den[i]));
      end
    end
    th = (h * $unsigned(s) + (longint'(1) << 29)) >> 30;
    rom[0] = '0;
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      d = (longint'(1) << 30) + ((t * th) >> 30);
      t = div_u64(((t + th) << 30) + (d >> 1), d);
      rom[i+1] = t[T_W-1:0];
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [CFG_DATA_W-1:0] v);
    if (v[GAIN_W-1:0] > GAIN_ONE) begin
      return GAIN_ONE;
    end
    return v[GAIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/tanh_saturator_with_mix.sv @@
// Tanh soft-clip saturator with pre/post gain and dry/wet mix: 14-stage pipeline.
// Depends on tsm_pkg for widths, register codes and the tanh table.
// Throughput: one beat per cycle while out_tready is high and the divider is not busy.
// Stages advance independently, so bubbles close up while the output is stalled.
// A write to saturation_amount starts a radix-2 reciprocal divider that holds
// in_tready low until the divide completes (one quotient bit per cycle).
// Reset (synchronous): registers return to defaults, pipeline and divider empty.
`default_nettype none

module tanh_saturator_with_mix
  import tsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [TDATA_W-1:0]    in_tdata,    // [23:0] sample_in
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [TDATA_W-1:0]    out_tdata,   // [23:0] sample_out
  output      logic                  out_tuser,   // [0] clipped
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [CFG_DATA_W-1:0] cfg_prdata,
  output      logic                  cfg_pready
);

  localparam int NST    = 14;
  localparam int X_W    = SAMPLE_BITS;
  localparam int PA_W   = X_W + GAIN_W + 1;
  localparam int A_W    = X_W + 2;
  localparam int MAG_W  = X_W + 1;
  localparam int MU_W   = MAG_W + KS_W;
  localparam int PR_W   = DIFF_W + FRAC_W;
  localparam int PPL_W  = T_W + RC_LO_W;
  localparam int PPH_W  = T_W + RC_W - RC_LO_W;
  localparam int SUM_W  = T_W + RC_W + 1;
  localparam int YM_W   = X_W + 2;
  localparam int Y_W    = YM_W + 1;
  localparam int PB_W   = Y_W + GAIN_W + 1;
  localparam int B_W    = X_W + 3;
  localparam int M1_W   = B_W + GAIN_W + 1;
  localparam int M2_W   = X_W + GAIN_W + 1;
  localparam int MS_W   = X_W + 22;
  localparam int O_W    = X_W + 6;
  localparam int U_SH   = X_W - 15;
  localparam int YM_SH  = 55 - X_W;

  localparam logic signed [PA_W-1:0] HALF15_PA = PA_W'(longint'(1) << 14);
  localparam logic signed [PB_W-1:0] HALF15_PB = PB_W'(longint'(1) << 14);
  localparam logic signed [MS_W-1:0] HALF16    = MS_W'(longint'(1) << 15);
  localparam logic [MU_W-1:0]  U_HALF  = MU_W'(longint'(1) << (U_SH - 1));
  localparam logic [SUM_W-1:0] YM_HALF = SUM_W'(longint'(1) << (YM_SH - 1));
  localparam logic signed [O_W-1:0] O_MAX = O_W'((longint'(1) << (X_W - 1)) - 1);
  localparam logic signed [O_W-1:0] O_MIN = -O_W'(longint'(1) << (X_W - 1));

  // ---------------- configuration ----------------
  logic [GAIN_W-1:0]    pre_r, sat_r, post_r, wet_r;
  logic [KS_W-1:0]      ks_r;
  logic                 busy_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIV_N_W-1:0]   div_q_r;
  logic [DIV_R_W-1:0]   div_rem_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;
  logic [GAIN_W-1:0]    wr_val;
  logic [DIV_R_W-1:0]   rem_sh;
  logic                 rem_ge;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_val     = clamp_gain(cfg_pwdata);
  assign rem_sh     = {div_rem_r[DIV_R_W-2:0], div_q_r[DIV_N_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, ks_r};

  always_comb begin
    case (cfg_idx)
      REG_PRE_GAIN: cfg_prdata = CFG_DATA_W'(pre_r);
      REG_SAT:      cfg_prdata = CFG_DATA_W'(sat_r);
      REG_POST:     cfg_prdata = CFG_DATA_W'(post_r);
      REG_WET:      cfg_prdata = CFG_DATA_W'(wet_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r     <= 17'h08000;
      sat_r     <= '0;
      post_r    <= 17'h08000;
      wet_r     <= GAIN_ONE;
      ks_r      <= '0;
      busy_r    <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_PRE_GAIN: pre_r <= wr_val;
          REG_SAT: begin
            sat_r     <= wr_val;
            ks_r      <= KS_W'({wr_val, 3'b000}) + KS_W'({wr_val, 1'b0});
            busy_r    <= 1'b1;
            div_cnt_r <= DIV_CNT_W'(DIV_N_W);
          end
          REG_POST:     post_r <= wr_val;
          REG_WET:      wet_r  <= wr_val;
          default: ;
        endcase
      end
      if (busy_r && !(cfg_wr && cfg_idx == REG_SAT)) begin
        div_cnt_r <= div_cnt_r - 1'b1;
        if (div_cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // reciprocal: floor((2^40 + 5s) / 10s), restoring
  always_ff @(posedge clk) begin
    if (cfg_wr && cfg_idx == REG_SAT) begin
      div_rem_r <= '0;
      div_q_r   <= {1'b1, (DIV_N_W-1)'(0)}
                   | DIV_N_W'(DIV_N_W'(wr_val) * DIV_N_W'(5));
    end else if (busy_r) begin
      div_rem_r <= rem_ge ? rem_sh - {1'b0, ks_r} : rem_sh;
      div_q_r   <= {div_q_r[DIV_N_W-2:0], rem_ge};
    end
  end

  // ---------------- pipeline control ----------------
  logic [NST:1] v_r;
  logic [NST:1] en;
  logic         in_acc;

  for (genvar k = 1; k <= NST; k++) begin : g_en
    assign en[k] = out_tready | ~(&v_r[NST:k]);
  end

  assign in_tready = en[1] & ~busy_r;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_acc;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- datapath ----------------
  logic signed [X_W-1:0]  x_r [1:12];
  logic signed [A_W-1:0]  a_r [2:9];
  logic signed [PA_W-1:0] pa1_r;
  logic [MU_W-1:0]        mu3_r;
  logic [U_W-1:0]         u4_r;
  logic [T_W-1:0]         lo5_r, lo6_r;
  logic [DIFF_W-1:0]      diff5_r;
  logic [FRAC_W-1:0]      frac5_r;
  logic [PR_W-1:0]        pr6_r;
  logic [T_W-1:0]         t7_r;
  logic [PPL_W-1:0]       ppl8_r;
  logic [PPH_W-1:0]       pph8_r;
  logic [YM_W-1:0]        ym9_r;
  logic signed [Y_W-1:0]  y10_r;
  logic signed [PB_W-1:0] pb11_r;
  logic signed [B_W-1:0]  b12_r;
  logic signed [M1_W-1:0] m1_13_r;
  logic signed [M2_W-1:0] m2_13_r;
  logic signed [X_W-1:0]  o_r;
  logic                   clip_r;

  logic signed [PA_W-1:0] pa_rnd;
  logic [MAG_W-1:0]       mag2;
  logic [MU_W-1:0]        mu_rnd;
  logic [IDX_W-1:0]       idx4;
  logic                   top4;
  logic [IDX_W:0]         lo_idx, hi_idx;
  logic [SUM_W-1:0]       ym_sum;
  logic signed [Y_W-1:0]  ym_s;
  logic signed [PB_W-1:0] pb_rnd;
  logic [GAIN_W-1:0]      dry;
  logic signed [MS_W-1:0] ms_rnd;
  logic signed [O_W-1:0]  o_full;

  always_comb begin
    pa_rnd = pa1_r + (pa1_r[PA_W-1] ? HALF15_PA - PA_W'(1) : HALF15_PA);
    mag2   = a_r[2][A_W-1] ? MAG_W'(-a_r[2]) : MAG_W'(a_r[2]);
    mu_rnd = mu3_r + U_HALF;
    idx4   = u4_r[FRAC_W +: IDX_W];
    top4   = |u4_r[U_W-1:FRAC_W+IDX_W];
    lo_idx = {1'b0, idx4};
    hi_idx = lo_idx + (IDX_W+1)'(1);
    ym_sum = SUM_W'(ppl8_r) + (SUM_W'(pph8_r) << RC_LO_W) + YM_HALF;
    ym_s   = $signed({1'b0, ym9_r});
    pb_rnd = pb11_r + (pb11_r[PB_W-1] ? HALF15_PB - PB_W'(1) : HALF15_PB);
    dry    = GAIN_ONE - wet_r;
    ms_rnd = MS_W'(m1_13_r) + MS_W'(m2_13_r);
    ms_rnd = ms_rnd + (ms_rnd[MS_W-1] ? HALF16 - MS_W'(1) : HALF16);
    o_full = ms_rnd[16 +: O_W];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_r[1] <= $signed(in_tdata[X_W-1:0]);
      pa1_r  <= $signed(in_tdata[X_W-1:0]) * $signed({1'b0, pre_r});
    end
    if (en[2]) begin
      x_r[2] <= x_r[1];
      a_r[2] <= pa_rnd[15 +: A_W];
    end
    if (en[3]) begin
      x_r[3] <= x_r[2];
      a_r[3] <= a_r[2];
      mu3_r  <= MU_W'(mag2) * MU_W'(ks_r);
    end
    if (en[4]) begin
      x_r[4] <= x_r[3];
      a_r[4] <= a_r[3];
      u4_r   <= mu_rnd[U_SH +: U_W];
    end
    if (en[5]) begin
      x_r[5]  <= x_r[4];
      a_r[5]  <= a_r[4];
      frac5_r <= u4_r[FRAC_W-1:0];
      if (top4) begin
        lo5_r   <= TANH_ROM[TANH_ENTRIES];
        diff5_r <= '0;
      end else begin
        lo5_r   <= TANH_ROM[lo_idx];
        diff5_r <= DIFF_W'(TANH_ROM[hi_idx] - TANH_ROM[lo_idx]);
      end
    end
    if (en[6]) begin
      x_r[6] <= x_r[5];
      a_r[6] <= a_r[5];
      lo6_r  <= lo5_r;
      pr6_r  <= PR_W'(diff5_r) * PR_W'(frac5_r);
    end
    if (en[7]) begin
      x_r[7] <= x_r[6];
      a_r[7] <= a_r[6];
      t7_r   <= lo6_r + T_W'(pr6_r >> FRAC_W);
    end
    if (en[8]) begin
      x_r[8] <= x_r[7];
      a_r[8] <= a_r[7];
      ppl8_r <= PPL_W'(t7_r) * PPL_W'(div_q_r[RC_LO_W-1:0]);
      pph8_r <= PPH_W'(t7_r) * PPH_W'(div_q_r[RC_W-1:RC_LO_W]);
    end
    if (en[9]) begin
      x_r[9] <= x_r[8];
      a_r[9] <= a_r[8];
      ym9_r  <= ym_sum[YM_SH +: YM_W];
    end
    if (en[10]) begin
      x_r[10] <= x_r[9];
      if (sat_r == '0) begin
        y10_r <= Y_W'(a_r[9]);
      end else begin
        y10_r <= a_r[9][A_W-1] ? -ym_s : ym_s;
      end
    end
    if (en[11]) begin
      x_r[11] <= x_r[10];
      pb11_r  <= y10_r * $signed({1'b0, post_r});
    end
    if (en[12]) begin
      x_r[12] <= x_r[11];
      b12_r   <= pb_rnd[15 +: B_W];
    end
    if (en[13]) begin
      m1_13_r <= b12_r * $signed({1'b0, wet_r});
      m2_13_r <= x_r[12] * $signed({1'b0, dry});
    end
    if (en[14]) begin
      if (o_full > O_MAX) begin
        o_r    <= O_MAX[X_W-1:0];
        clip_r <= 1'b1;
      end else if (o_full < O_MIN) begin
        o_r    <= O_MIN[X_W-1:0];
        clip_r <= 1'b1;
      end else begin
        o_r    <= o_full[X_W-1:0];
        clip_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = v_r[NST];
  assign out_tdata  = TDATA_W'($unsigned(o_r));
  assign out_tuser  = clip_r;

endmodule

`default_nettype wire

@@ rtl/tsm_checker.sv @@
// Port-level checker for tanh_saturator_with_mix, attached by bind.
// Depends on tsm_pkg for widths, full-scale codes and register codes.
`default_nettype none

module tsm_checker
  import tsm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [TDATA_W-1:0]    out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  cfg_psel,
  input wire logic                  cfg_penable,
  input wire logic                  cfg_pwrite,
  input wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input wire logic                  cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_clip_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[SAMPLE_BITS-1:0] == FS_POS || out_tdata[SAMPLE_BITS-1:0] == FS_NEG)
    else $error("clipped beat not at full scale");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  a_drive_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
      && cfg_paddr[CFG_ADDR_W-1:2] == REG_SAT |=> !in_tready)
    else $error("input accepted while reciprocal is being rebuilt");

endmodule

bind tanh_saturator_with_mix tsm_checker u_tsm_checker (.*);

`default_nettype wire
